[design/assert_macros.svh]
// Assertion macros shared by the quaternion slerp RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_AFTER(label, ck, rn, ante, dly, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

[design/qslerp_pkg.sv]
// Types, widths and constant tables for the quaternion slerp pipeline.
// Depends on nothing; used by every module of the block.
package qslerp_pkg;

    localparam int COMP_W       = 16;
    localparam int ANGLE_W      = 17;
    localparam int VEC_W        = 34;
    localparam int Z_W          = 20;
    localparam int UNIT_W       = 31;
    localparam int QUO_W        = 27;
    localparam int REM_W        = UNIT_W + 16;
    localparam int DOT_W        = 34;
    localparam int DOT_SHIFT    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int ACOS_STEPS   = 17;
    localparam int ONE_Q16      = 65536;
    localparam int ONE_Q30      = 1073741824;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int MIN_SINE     = 1048576;

    localparam logic [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd32768, 17'd19344, 17'd10221, 17'd5188, 17'd2604, 17'd1303, 17'd652, 17'd326,
        17'd163, 17'd81, 17'd41, 17'd20, 17'd10, 17'd5, 17'd3, 17'd1
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] first_x;
        logic signed [COMP_W-1:0] first_y;
        logic signed [COMP_W-1:0] first_z;
        logic signed [COMP_W-1:0] first_w;
        logic signed [COMP_W-1:0] second_x;
        logic signed [COMP_W-1:0] second_y;
        logic signed [COMP_W-1:0] second_z;
        logic signed [COMP_W-1:0] second_w;
        logic [ANGLE_W-1:0]       blend;
    } in_beat_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     took_linear;
        logic                     was_flipped;
    } out_beat_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } cordic_vec_t;

    typedef struct packed {
        logic [3:0][COMP_W-1:0] q1;
        logic [3:0][COMP_W-1:0] q2;
        logic [ANGLE_W-1:0]     t;
        logic                   same;
        logic                   flipped;
        logic                   linear;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        logic [UNIT_W-1:0]  target;
        item_t              item;
    } srch_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] theta;
        item_t              item;
    } sine_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem0;
        logic [REM_W-1:0] rem1;
        logic [QUO_W-1:0] quo0;
        logic [QUO_W-1:0] quo1;
        logic [UNIT_W-1:0] den;
    } div_vec_t;

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [VEC_W-1:0] v);
        logic [UNIT_W-1:0] r;
        if (v[VEC_W-1])
        begin
            r = '0;
        end
        else if (v > VEC_W'(ONE_Q30))
        begin
            r = UNIT_W'(ONE_Q30);
        end
        else
        begin
            r = v[UNIT_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/qslerp_cordic_cell.sv]
// One registered CORDIC micro-rotation with a side word carried alongside.
// Depends on qslerp_pkg.
module qslerp_cordic_cell #(
    parameter int unsigned STEP   = 0,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  qslerp_pkg::cordic_vec_t   in_vec,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_vld,
    output qslerp_pkg::cordic_vec_t   out_vec,
    output logic [SIDE_W-1:0]         out_side
);
    import qslerp_pkg::*;

    logic                    vld_reg;
    cordic_vec_t             vec_reg;
    cordic_vec_t             vec_next;
    logic [SIDE_W-1:0]       side_reg;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [Z_W-1:0]   da;

    always_comb
    begin
        dx = in_vec.y >>> STEP;
        dy = in_vec.x >>> STEP;
        da = Z_W'(ATAN_TAB[STEP]);
        if (!in_vec.z[Z_W-1])
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - da;
        end
        else
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_vec  = vec_reg;
    assign out_side = side_reg;

endmodule

[design/qslerp_cordic.sv]
// Rotation-mode CORDIC built as a row of micro-rotation cells.
// Depends on qslerp_pkg and qslerp_cordic_cell.
module qslerp_cordic #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic [qslerp_pkg::ANGLE_W-1:0]    angle,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_vld,
    output qslerp_pkg::cordic_vec_t           out_vec,
    output logic [SIDE_W-1:0]                 out_side
);
    import qslerp_pkg::*;

    logic              vld_w  [CORDIC_STEPS+1];
    cordic_vec_t       vec_w  [CORDIC_STEPS+1];
    logic [SIDE_W-1:0] side_w [CORDIC_STEPS+1];

    assign vld_w[0]  = in_vld;
    assign vec_w[0]  = {VEC_W'(CORDIC_GAIN), {VEC_W{1'b0}}, Z_W'(angle)};
    assign side_w[0] = in_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        qslerp_cordic_cell #(
            .STEP   (i),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld_w[i]),
            .in_vec   (vec_w[i]),
            .in_side  (side_w[i]),
            .out_vld  (vld_w[i+1]),
            .out_vec  (vec_w[i+1]),
            .out_side (side_w[i+1])
        );
    end

    assign out_vld  = vld_w[CORDIC_STEPS];
    assign out_vec  = vec_w[CORDIC_STEPS];
    assign out_side = side_w[CORDIC_STEPS];

endmodule

[design/qslerp_div_cell.sv]
// One registered restoring-division step for both weights, sharing the divisor.
// Depends on qslerp_pkg.
module qslerp_div_cell #(
    parameter int unsigned BIT    = 0,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  qslerp_pkg::div_vec_t    in_vec,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_vld,
    output qslerp_pkg::div_vec_t    out_vec,
    output logic [SIDE_W-1:0]       out_side
);
    import qslerp_pkg::*;

    localparam int EXT_W = UNIT_W + QUO_W;

    logic              vld_reg;
    div_vec_t          vec_reg;
    div_vec_t          vec_next;
    logic [SIDE_W-1:0] side_reg;
    logic [EXT_W-1:0]  trial;
    logic [EXT_W-1:0]  ext0;
    logic [EXT_W-1:0]  ext1;

    always_comb
    begin
        vec_next = in_vec;
        trial    = EXT_W'(in_vec.den) << BIT;
        ext0     = EXT_W'(in_vec.rem0);
        ext1     = EXT_W'(in_vec.rem1);
        if (ext0 >= trial)
        begin
            vec_next.rem0      = REM_W'(ext0 - trial);
            vec_next.quo0[BIT] = 1'b1;
        end
        if (ext1 >= trial)
        begin
            vec_next.rem1      = REM_W'(ext1 - trial);
            vec_next.quo1[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_vec  = vec_reg;
    assign out_side = side_reg;

endmodule

[design/quaternion_slerp.sv]
// Top level of the fixed-point quaternion slerp pipeline.
// Depends on qslerp_pkg, qslerp_cordic, qslerp_div_cell and assert_macros.svh.
//
//   channel   signals                          beat taken when
//   input     start, busy, operands            start high, busy low
//   result    done, result                     done high (cannot be held off)
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// One beat enters every cycle; busy stays low. The pipeline depth from an input beat
// to its result beat is set mostly by the arc-cosine search: 17 steps, each a 16-cell
// CORDIC row and a compare stage, then two more CORDIC rows deep and a 27-cell divider.
// Reset clears the valid bits and loads the threshold with 6554; no clearing pass.
`include "assert_macros.svh"

module quaternion_slerp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  qslerp_pkg::in_beat_t  operands,
    output logic                  done,
    output qslerp_pkg::out_beat_t result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);
    import qslerp_pkg::*;

    localparam int MUL_W   = QUO_W + COMP_W + 2;
    localparam int ACC_W   = MUL_W + 1;
    localparam int LATENCY = 3 + ACOS_STEPS * (CORDIC_STEPS + 1) + CORDIC_STEPS + 1
                             + CORDIC_STEPS + 1 + QUO_W + 2;

    logic [15:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd6554;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Input register.
    logic  in_vld_reg;
    item_t in_reg;
    item_t in_next;

    always_comb
    begin
        in_next.q1 = {operands.first_w, operands.first_z, operands.first_y, operands.first_x};
        in_next.q2 = {operands.second_w, operands.second_z, operands.second_y,
                      operands.second_x};
        in_next.t  = (operands.blend > ANGLE_W'(ONE_Q16)) ? ANGLE_W'(ONE_Q16) : operands.blend;
        in_next.same    = (in_next.q1 == in_next.q2);
        in_next.flipped = 1'b0;
        in_next.linear  = 1'b0;
    end

    // Products of the dot.
    logic                         prod_vld_reg;
    item_t                        prod_item_reg;
    logic signed [2*COMP_W-1:0]   prod_reg  [4];
    logic signed [2*COMP_W-1:0]   prod_next [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = $signed(in_reg.q1[i]) * $signed(in_reg.q2[i]);
        end
    end

    // Dot sum, shortest-path flip and linear decision.
    logic                    dot_vld_reg;
    srch_t                   dot_reg;
    srch_t                   dot_next;
    logic signed [DOT_W-1:0] dot;
    logic [DOT_W-1:0]        dot_mag;
    logic [DOT_W-DOT_SHIFT-1:0] d16_raw;
    logic [ANGLE_W-1:0]      d16;

    always_comb
    begin
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2])
              + DOT_W'(prod_reg[3]);
        dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
        d16_raw = dot_mag[DOT_W-1:DOT_SHIFT];
        d16 = (d16_raw > (DOT_W-DOT_SHIFT)'(ONE_Q16)) ? ANGLE_W'(ONE_Q16)
                                                      : d16_raw[ANGLE_W-1:0];
        dot_next.lo     = '0;
        dot_next.hi     = ANGLE_W'(ONE_Q16);
        dot_next.target = {d16, {DOT_SHIFT{1'b0}}};
        dot_next.item   = prod_item_reg;
        dot_next.item.flipped = dot[DOT_W-1];
        dot_next.item.linear  = (ANGLE_W'(ONE_Q16) - d16) <= {1'b0, thr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            dot_vld_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= start && !busy;
            prod_vld_reg <= in_vld_reg;
            dot_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        prod_item_reg <= in_reg;
        prod_reg      <= prod_next;
        dot_reg       <= dot_next;
    end

    // Arc-cosine by binary search, one CORDIC row per step.
    logic  srch_vld [ACOS_STEPS+1];
    srch_t srch     [ACOS_STEPS+1];

    assign srch_vld[0] = dot_vld_reg;
    assign srch[0]     = dot_reg;

    for (genvar k = 0; k < ACOS_STEPS; k++)
    begin : g_search
        logic [ANGLE_W:0]     mid_sum;
        logic [ANGLE_W-1:0]   mid;
        logic                 c_vld;
        cordic_vec_t          c_vec;
        logic [$bits(srch_t)-1:0] c_side;
        srch_t                cs;
        logic [ANGLE_W:0]     cs_sum;
        logic [ANGLE_W-1:0]   cs_mid;
        logic [UNIT_W-1:0]    cosv;
        srch_t                cmp_next;
        srch_t                cmp_reg;
        logic                 cmp_vld_reg;

        assign mid_sum = {1'b0, srch[k].lo} + {1'b0, srch[k].hi};
        assign mid     = mid_sum[ANGLE_W:1];

        qslerp_cordic #(
            .SIDE_W ($bits(srch_t))
        ) u_cordic (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (srch_vld[k]),
            .angle    (mid),
            .in_side  (srch[k]),
            .out_vld  (c_vld),
            .out_vec  (c_vec),
            .out_side (c_side)
        );

        always_comb
        begin
            cs       = c_side;
            cs_sum   = {1'b0, cs.lo} + {1'b0, cs.hi};
            cs_mid   = cs_sum[ANGLE_W:1];
            cosv     = clamp_unit(c_vec.x);
            cmp_next = cs;
            if (cs.lo < cs.hi)
            begin
                if (cosv > cs.target)
                begin
                    cmp_next.lo = cs_mid + ANGLE_W'(1);
                end
                else
                begin
                    cmp_next.hi = cs_mid;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cmp_vld_reg <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= c_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            cmp_reg <= cmp_next;
        end

        assign srch_vld[k+1] = cmp_vld_reg;
        assign srch[k+1]     = cmp_reg;
    end

    // Sine of theta.
    sine_side_t                     sin_in;
    logic                           sin_vld;
    cordic_vec_t                    sin_vec;
    logic [$bits(sine_side_t)-1:0]  sin_side;
    sine_side_t                     sin_out;

    assign sin_in.theta = srch[ACOS_STEPS].lo;
    assign sin_in.item  = srch[ACOS_STEPS].item;

    qslerp_cordic #(
        .SIDE_W ($bits(sine_side_t))
    ) u_sin_theta (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (srch_vld[ACOS_STEPS]),
        .angle    (srch[ACOS_STEPS].lo),
        .in_side  (sin_in),
        .out_vld  (sin_vld),
        .out_vec  (sin_vec),
        .out_side (sin_side)
    );

    // Partial angles.
    logic               ang_vld_reg;
    item_t              ang_item_reg;
    logic [ANGLE_W-1:0] a0_reg;
    logic [ANGLE_W-1:0] a1_reg;
    logic [UNIT_W-1:0]  st_reg;
    logic [2*ANGLE_W-1:0] p0;
    logic [2*ANGLE_W-1:0] p1;

    always_comb
    begin
        sin_out = sin_side;
        p0 = (ANGLE_W'(ONE_Q16) - sin_out.item.t) * sin_out.theta;
        p1 = sin_out.item.t * sin_out.theta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_vld_reg <= 1'b0;
        end
        else
        begin
            ang_vld_reg <= sin_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_item_reg <= sin_out.item;
        a0_reg       <= p0[16 +: ANGLE_W];
        a1_reg       <= p1[16 +: ANGLE_W];
        st_reg       <= clamp_unit(sin_vec.y);
    end

    // Sines of the partial angles.
    logic                      s0_vld;
    cordic_vec_t               s0_vec;
    logic [$bits(item_t)-1:0]  s0_side;
    logic                      s1_vld;
    cordic_vec_t               s1_vec;
    logic [UNIT_W-1:0]         s1_side;

    qslerp_cordic #(
        .SIDE_W ($bits(item_t))
    ) u_sin_a0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (ang_vld_reg),
        .angle    (a0_reg),
        .in_side  (ang_item_reg),
        .out_vld  (s0_vld),
        .out_vec  (s0_vec),
        .out_side (s0_side)
    );

    qslerp_cordic #(
        .SIDE_W (UNIT_W)
    ) u_sin_a1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (ang_vld_reg),
        .angle    (a1_reg),
        .in_side  (st_reg),
        .out_vld  (s1_vld),
        .out_vec  (s1_vec),
        .out_side (s1_side)
    );

    // Divider set-up.
    logic     divp_vld_reg;
    item_t    divp_item_reg;
    item_t    divp_item_next;
    div_vec_t divp_reg;
    div_vec_t divp_next;

    always_comb
    begin
        divp_item_next        = s0_side;
        divp_item_next.linear = divp_item_next.linear || (s1_side == '0);
        divp_next.rem0 = {clamp_unit(s0_vec.y), 16'b0};
        divp_next.rem1 = {clamp_unit(s1_vec.y), 16'b0};
        divp_next.quo0 = '0;
        divp_next.quo1 = '0;
        divp_next.den  = s1_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divp_vld_reg <= 1'b0;
        end
        else
        begin
            divp_vld_reg <= s0_vld && s1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        divp_item_reg <= divp_item_next;
        divp_reg      <= divp_next;
    end

    // Weight division, one quotient bit per cell.
    logic                     div_vld  [QUO_W+1];
    div_vec_t                 div_v    [QUO_W+1];
    logic [$bits(item_t)-1:0] div_side [QUO_W+1];

    assign div_vld[0]  = divp_vld_reg;
    assign div_v[0]    = divp_reg;
    assign div_side[0] = divp_item_reg;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        qslerp_div_cell #(
            .BIT    (QUO_W - 1 - j),
            .SIDE_W ($bits(item_t))
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (div_vld[j]),
            .in_vec   (div_v[j]),
            .in_side  (div_side[j]),
            .out_vld  (div_vld[j+1]),
            .out_vec  (div_v[j+1]),
            .out_side (div_side[j+1])
        );
    end

    // Weighted products.
    item_t                     fi;
    div_vec_t                  dv;
    logic [QUO_W-1:0]          w0;
    logic [QUO_W-1:0]          w1;
    logic signed [COMP_W:0]    bv [4];
    logic signed [MUL_W-1:0]   mul0_next [4];
    logic signed [MUL_W-1:0]   mul1_next [4];
    logic signed [MUL_W-1:0]   mul0_reg  [4];
    logic signed [MUL_W-1:0]   mul1_reg  [4];
    logic                      mul_vld_reg;
    item_t                     mul_item_reg;

    always_comb
    begin
        fi = div_side[QUO_W];
        dv = div_v[QUO_W];
        w0 = fi.linear ? (QUO_W'(ONE_Q16) - QUO_W'(fi.t)) : dv.quo0;
        w1 = fi.linear ? QUO_W'(fi.t) : dv.quo1;
        for (int i = 0; i < 4; i++)
        begin
            bv[i] = $signed({fi.q2[i][COMP_W-1], fi.q2[i]});
            if (fi.flipped)
            begin
                bv[i] = -bv[i];
            end
            mul0_next[i] = $signed({1'b0, w0}) * $signed(fi.q1[i]);
            mul1_next[i] = $signed({1'b0, w1}) * bv[i];
        end
    end

    // Rounding, saturation and the identical-input bypass.
    logic signed [ACC_W-1:0] acc [4];
    logic signed [ACC_W-1:0] shv [4];
    logic [3:0][COMP_W-1:0]  comp;
    out_beat_t               result_next;
    out_beat_t               result_reg;
    logic                    done_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = ACC_W'(mul0_reg[i]) + ACC_W'(mul1_reg[i]) + ACC_W'(32768);
            shv[i] = acc[i] >>> 16;
            if (mul_item_reg.same)
            begin
                comp[i] = mul_item_reg.q1[i];
            end
            else if (shv[i] > ACC_W'(32767))
            begin
                comp[i] = 16'h7fff;
            end
            else if (shv[i] < -ACC_W'(32768))
            begin
                comp[i] = 16'h8000;
            end
            else
            begin
                comp[i] = shv[i][COMP_W-1:0];
            end
        end
        result_next.out_x       = comp[0];
        result_next.out_y       = comp[1];
        result_next.out_z       = comp[2];
        result_next.out_w       = comp[3];
        result_next.took_linear = mul_item_reg.linear && !mul_item_reg.same;
        result_next.was_flipped = mul_item_reg.flipped && !mul_item_reg.same;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= div_vld[QUO_W];
            done_reg    <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_item_reg <= fi;
        mul0_reg     <= mul0_next;
        mul1_reg     <= mul1_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_AFTER(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    `ASSERT_IMPLY(a_search_closed, clk, rst_n, srch_vld[ACOS_STEPS], srch[ACOS_STEPS].lo == srch[ACOS_STEPS].hi)
    `ASSERT_IMPLY(a_divisor_range, clk, rst_n, divp_vld_reg && !divp_item_reg.linear, divp_reg.den >= UNIT_W'(MIN_SINE))

endmodule

[verif/slerp_checker.sv]
// Checker for the quaternion slerp block: it watches the input, result and threshold channels.
// It predicts each result in fixed point and compares it field by field. Depends on qslerp_pkg.
module slerp_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  qslerp_pkg::in_beat_t  operands,
    input  logic                  done,
    input  qslerp_pkg::out_beat_t result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import qslerp_pkg::*;

    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam int     STEP_CNT = 16;
    localparam int     ARC_TAB [STEP_CNT] = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
                                              163, 81, 41, 20, 10, 5, 3, 1};

    logic [15:0] lin_limit;
    out_beat_t   slerp_q[$];

    function automatic longint unit_clip(input longint v);
        longint r;
        r = v;
        if (v < 0)
        begin
            r = 0;
        end
        else if (v > UNIT_Q30)
        begin
            r = UNIT_Q30;
        end
        return r;
    endfunction

    function automatic void rotate(input int angle, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        int     z;
        x = 64'sd652032874;
        y = 0;
        z = angle;
        for (int i = 0; i < STEP_CNT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_TAB[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_TAB[i];
            end
        end
        c = unit_clip(x);
        s = unit_clip(y);
    endfunction

    function automatic longint sin_of(input int angle);
        longint c;
        longint s;
        rotate(angle, c, s);
        return s;
    endfunction

    function automatic int angle_of_cos(input longint d16);
        int     lo;
        int     hi;
        int     mid;
        longint c;
        longint s;
        longint target;
        lo = 0;
        hi = 65536;
        target = d16 <<< 14;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            rotate(mid, c, s);
            if (c > target)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic logic [15:0] round_sat(input longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic out_beat_t slerp_of(input in_beat_t b, input logic [15:0] limit);
        longint    p [4];
        longint    q [4];
        longint    dot;
        longint    d16;
        longint    w0;
        longint    w1;
        longint    t;
        longint    st;
        int        theta;
        logic      linear;
        out_beat_t r;
        p = '{b.first_x, b.first_y, b.first_z, b.first_w};
        q = '{b.second_x, b.second_y, b.second_z, b.second_w};
        t = (b.blend > 65536) ? 65536 : longint'(b.blend);
        r = '0;
        if (p == q)
        begin
            r.out_x = p[0][15:0];
            r.out_y = p[1][15:0];
            r.out_z = p[2][15:0];
            r.out_w = p[3][15:0];
            return r;
        end
        dot = p[0] * q[0] + p[1] * q[1] + p[2] * q[2] + p[3] * q[3];
        if (dot < 0)
        begin
            r.was_flipped = 1'b1;
            dot = -dot;
            for (int i = 0; i < 4; i++)
            begin
                q[i] = -q[i];
            end
        end
        d16 = dot >>> 14;
        if (d16 > 65536)
        begin
            d16 = 65536;
        end
        linear = (65536 - d16) <= longint'(limit);
        w0 = 65536 - t;
        w1 = t;
        if (!linear)
        begin
            theta = angle_of_cos(d16);
            st = sin_of(theta);
            if (st == 0)
            begin
                linear = 1'b1;
            end
            else
            begin
                w0 = (sin_of(int'(((65536 - t) * theta) >>> 16)) <<< 16) / st;
                w1 = (sin_of(int'((t * theta) >>> 16)) <<< 16) / st;
            end
        end
        r.out_x = round_sat(w0 * p[0] + w1 * q[0]);
        r.out_y = round_sat(w0 * p[1] + w1 * q[1]);
        r.out_z = round_sat(w0 * p[2] + w1 * q[2]);
        r.out_w = round_sat(w0 * p[3] + w1 * q[3]);
        r.took_linear = linear;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            lin_limit   <= 16'd6554;
            fail_count  <= 0;
            outstanding <= 0;
            slerp_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (slerp_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = slerp_q.pop_front();
                    if (e !== result)
                    begin
                        fail_count <= fail_count + 1;
                    end
                    if (e.out_x !== result.out_x)
                    begin
                        $error("out_x expected %0d got %0d", e.out_x, result.out_x);
                    end
                    if (e.out_y !== result.out_y)
                    begin
                        $error("out_y expected %0d got %0d", e.out_y, result.out_y);
                    end
                    if (e.out_z !== result.out_z)
                    begin
                        $error("out_z expected %0d got %0d", e.out_z, result.out_z);
                    end
                    if (e.out_w !== result.out_w)
                    begin
                        $error("out_w expected %0d got %0d", e.out_w, result.out_w);
                    end
                    if (e.took_linear !== result.took_linear)
                    begin
                        $error("took_linear expected %0d got %0d", e.took_linear,
                               result.took_linear);
                    end
                    if (e.was_flipped !== result.was_flipped)
                    begin
                        $error("was_flipped expected %0d got %0d", e.was_flipped,
                               result.was_flipped);
                    end
                end
            end
            if (start && !busy)
            begin
                slerp_q.insert(slerp_q.size(), slerp_of(operands, lin_limit));
            end
            if (cfg_valid && cfg_ready)
            begin
                lin_limit <= cfg_data;
            end
            outstanding <= slerp_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the quaternion slerp testbench: clock, reset, stimulus, threshold writes and verdict.
// Depends on qslerp_pkg, quaternion_slerp and slerp_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qslerp_pkg::*;

    localparam int DRAIN_CYCLES = 360;
    localparam int CYCLE_LIMIT  = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_beat_t    operands = '0;
    logic        done;
    out_beat_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          outstanding;
    int          cycle_cnt = 0;
    int          idle_pct = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    quaternion_slerp u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operands(operands),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    slerp_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operands(operands),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] clip16(input int v);
        int r;
        r = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return r[15:0];
    endfunction

    function automatic in_beat_t beat(input int ax, input int ay, input int az, input int aw,
                                      input int bx, input int by, input int bz, input int bw,
                                      input int t);
        in_beat_t b;
        b.first_x = clip16(ax);
        b.first_y = clip16(ay);
        b.first_z = clip16(az);
        b.first_w = clip16(aw);
        b.second_x = clip16(bx);
        b.second_y = clip16(by);
        b.second_z = clip16(bz);
        b.second_w = clip16(bw);
        b.blend = t[16:0];
        return b;
    endfunction

    task automatic send(input in_beat_t b);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct)
            begin
                @(posedge clk);
            end
            @(posedge clk);
        end
        start <= 1'b1;
        operands <= b;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_blend();
        int k;
        k = $urandom_range(19);
        if (k == 0)
        begin
            return 0;
        end
        if (k == 1)
        begin
            return 65536;
        end
        if (k == 2)
        begin
            return $urandom_range(131071, 65537);
        end
        return $urandom_range(65536);
    endfunction

    function automatic in_beat_t rand_item();
        int a [4];
        int d [4];
        int spread;
        int k;
        k = $urandom_range(99);
        if (k < 20)
        begin
            return beat($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        rand_blend());
        end
        for (int i = 0; i < 4; i++)
        begin
            a[i] = $urandom_range(32768) - 16384;
        end
        if (k < 23)
        begin
            return beat(a[0], a[1], a[2], a[3], a[0], a[1], a[2], a[3], rand_blend());
        end
        spread = (k < 50) ? 64 : ((k < 75) ? 2000 : 14000);
        for (int i = 0; i < 4; i++)
        begin
            d[i] = a[i] + $urandom_range(2 * spread) - spread;
            if ($urandom_range(1) == 1 && k >= 60)
            begin
                d[i] = -d[i];
            end
        end
        if ($urandom_range(3) == 0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d[i] = -d[i];
            end
        end
        return beat(a[0], a[1], a[2], a[3], d[0], d[1], d[2], d[3], rand_blend());
    endfunction

    initial
    begin
        logic [15:0] limits [8];
        limits = '{16'd0, 16'd65535, 16'd6554, 16'd200, 16'd0, 16'd30000, 16'd65535, 16'd6554};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(beat(12000, -5000, 300, 30000, 12000, -5000, 300, 30000, 40000));
        send(beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
        send(beat(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
        send(beat(32767, 0, 0, 0, 0, 32767, 0, 0, 0));
        send(beat(32767, 0, 0, 0, 0, 32767, 0, 0, 65536));
        send(beat(32767, 0, 0, 0, 0, 32767, 0, 0, 131071));
        send(beat(32767, 0, 0, 0, 0, 32767, 0, 0, 70000));
        send(beat(0, 0, 0, 32767, 0, 0, 0, -32767, 20000));
        send(beat(0, 0, 23170, 23170, 0, 0, -23170, -23170, 50000));
        send(beat(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 30000));
        send(beat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32766, 30000));
        send(beat(32767, 32767, 32767, 32767, 32000, -32768, 32767, 32767, 10000));
        send(beat(0, 0, 0, 0, 0, 0, 0, 32767, 32768));
        send(beat(0, 0, 0, 32767, 100, 0, 0, 32767, 16384));
        send(beat(0, 0, 0, 32767, 3000, 0, 0, 32600, 16384));
        send(beat(0, 0, 16384, 28378, 0, 0, -16384, 28378, 45000));
        send(beat(16384, 16384, 16384, 16384, 16384, -16384, 16384, 16384, 1));
        send(beat(-1, 1, -1, 1, 1, -1, 1, -1, 65535));
        send(beat(0, 0, 0, 1, 0, 0, 0, 0, 30000));

        for (int ph = 0; ph < 8; ph++)
        begin
            set_limit(ph == 0 ? 16'd6554 : limits[ph]);
            idle_pct = (ph % 4 == 1) ? 66 : ((ph % 4 == 3) ? 24 : 0);
            for (int n = 0; n < 190; n++)
            begin
                send(rand_item());
            end
        end
        start <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
